[rtl/core/cconv_pkg.sv]
// Shared types and constants for the clamped 3x3 RGB convolution block.
`default_nettype none

package cconv_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CHANNELS    = 3;
    localparam int RGB_W       = PIXEL_W * CHANNELS;
    localparam int TAPS        = 9;
    localparam int PROD_W      = 16;
    localparam int ROW_SUM_W   = 18;
    localparam int SUM_W       = 20;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W       = 12;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_index;

    typedef logic [RGB_W-1:0] t_pixel;

    // kernel row a, tap b at bits [8*b +: 8]
    typedef logic [2:0][CFG_DATA_W-1:0] t_kernel;

    typedef struct packed {
        t_pixel [TAPS-1:0] taps;
        logic              frame_end;
    } t_tap_item;

endpackage

`default_nettype wire

[rtl/core/cconv_mac.sv]
// Multiply and sum pipeline: 27 tap products, per-row sums, final channel sums.
`default_nettype none

module cconv_mac (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire cconv_pkg::t_tap_item                  i_item,
    input  wire cconv_pkg::t_kernel                    i_kernel,
    output logic                                       o_stall,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [cconv_pkg::SUM_W-1:0]         o_red_sum,
    output logic signed [cconv_pkg::SUM_W-1:0]         o_green_sum,
    output logic signed [cconv_pkg::SUM_W-1:0]         o_blue_sum,
    output logic                                       o_frame_end
);

    localparam int PW = cconv_pkg::PROD_W;
    localparam int RW = cconv_pkg::ROW_SUM_W;
    localparam int SW = cconv_pkg::SUM_W;
    localparam int NC = cconv_pkg::CHANNELS;
    localparam int NT = cconv_pkg::TAPS;
    localparam int BW = cconv_pkg::PIXEL_W;

    logic signed [PW-1:0] n_prod [NT][NC];
    logic signed [PW-1:0] r_prod [NT][NC];
    logic                 r_p1_valid;
    logic                 r_p1_fe;

    logic signed [RW-1:0] n_row [3][NC];
    logic signed [RW-1:0] r_row [3][NC];
    logic                 r_p2_valid;
    logic                 r_p2_fe;

    logic signed [SW-1:0] n_sum [NC];
    logic signed [SW-1:0] r_sum [NC];
    logic                 r_out_valid;
    logic                 r_out_fe;

    logic out_ready;
    logic p2_ready;
    logic p1_ready;
    logic p1_load;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign p2_ready  = !r_p2_valid || out_ready;
    assign p1_ready  = !r_p1_valid || p2_ready;
    assign p1_load   = i_valid && p1_ready;
    assign o_stall   = !p1_ready;

    always_comb begin
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] cf;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                for (int ch = 0; ch < NC; ch++) begin
                    px = PW'($signed({1'b0, i_item.taps[a*3+b][BW*ch +: BW]}));
                    cf = PW'($signed(i_kernel[a][BW*b +: BW]));
                    n_prod[a*3+b][ch] = px * cf;
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int ch = 0; ch < NC; ch++) begin
                n_row[a][ch] = RW'(r_prod[a*3][ch]) + RW'(r_prod[a*3+1][ch])
                             + RW'(r_prod[a*3+2][ch]);
            end
        end
        for (int ch = 0; ch < NC; ch++) begin
            n_sum[ch] = SW'(r_row[0][ch]) + SW'(r_row[1][ch]) + SW'(r_row[2][ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (p1_ready) begin
                r_p1_valid <= i_valid;
            end
            if (p2_ready) begin
                r_p2_valid <= r_p1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_p2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_load) begin
            r_prod  <= n_prod;
            r_p1_fe <= i_item.frame_end;
        end
        if (p2_ready && r_p1_valid) begin
            r_row   <= n_row;
            r_p2_fe <= r_p1_fe;
        end
        if (out_ready && r_p2_valid) begin
            r_sum    <= n_sum;
            r_out_fe <= r_p2_fe;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_sum   = r_sum[0];
    assign o_green_sum = r_sum[1];
    assign o_blue_sum  = r_sum[2];
    assign o_frame_end = r_out_fe;

endmodule

`default_nettype wire

[rtl/core/clamped_3x3_image_convolution.sv]
// Top level of the streaming 3x3 RGB convolution with edge replication.
//
// Pixels enter in raster order on the input channel (i_in_valid / o_in_stall);
// a transfer happens on a clock edge with valid high and stall low. Results
// leave on the output channel (o_out_valid / i_out_stall) one line plus one
// pixel behind the input, in raster order except the last two lines, which
// interleave; the last input line also flushes its own results, the final
// one flagged by o_frame_end. Throughput: one pixel per cycle unless stalled.
// A pixel with several results holds the input until all but its last have
// issued: the last pixel of a line gives 2, pixels of the last line past
// column 0 give 2, the frame's last pixel 4, pixels of the first line none.
// A pixel's first result passes, in order, the read stage, window/job, tap
// select, multiply, row sum and channel sum registers; further results of
// the same pixel follow one per cycle while nothing stalls.
// The line store is one synchronous RAM of MAX_WIDTH entries holding the two
// previous lines; back-to-back hits on one entry (width 1) are forwarded.
// Reset (synchronous, active low) restores width 1024, height 1024, zero
// kernel, the frame position and an empty pipeline; the RAM is not cleared.
// On a receiver stall the output holds, the pipeline fills, then o_in_stall
// rises. Write configuration only while idle; the block does not enforce it.
`default_nettype none

module clamped_3x3_image_convolution #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [cconv_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [cconv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [cconv_pkg::PIXEL_W-1:0]         i_red,
    input  wire logic [cconv_pkg::PIXEL_W-1:0]         i_green,
    input  wire logic [cconv_pkg::PIXEL_W-1:0]         i_blue,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [cconv_pkg::SUM_W-1:0]         o_red_sum,
    output logic signed [cconv_pkg::SUM_W-1:0]         o_green_sum,
    output logic signed [cconv_pkg::SUM_W-1:0]         o_blue_sum,
    output logic                                       o_frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > cconv_pkg::WIDTH_REG_W) ?
                         $clog2(MAX_WIDTH + 1) : cconv_pkg::WIDTH_REG_W;
    localparam int PXW = cconv_pkg::RGB_W;
    localparam int LW  = 2 * PXW;
    localparam int HW  = cconv_pkg::HEIGHT_REG_W;
    localparam int RW  = cconv_pkg::ROW_W;

    typedef struct packed {
        logic [3:0] mask;
        logic       c_is0;
        logic       c_is1;
        logic       r_is0;
        logic       r_is1;
    } t_job_ctl;

    // configuration
    logic [cconv_pkg::WIDTH_REG_W-1:0] r_cfg_width;
    logic [HW-1:0]                     r_cfg_height;
    cconv_pkg::t_kernel                r_kernel;

    // frame position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [WW-1:0] w_ext;
    logic [WW-1:0] w_lim;
    logic [CW-1:0] col_last;
    logic [HW-1:0] h_lim;
    logic [RW-1:0] row_last;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic          last_col;
    logic          last_row;
    t_job_ctl      n_s1_ctl;

    // line store read stage
    logic [LW-1:0]            r_line_mem [MAX_WIDTH];
    logic [LW-1:0]            r_rdata;
    logic [LW-1:0]            r_fwd_data;
    logic                     r_s1_fwd;
    logic                     r_s1_valid;
    cconv_pkg::t_pixel        r_s1_pix;
    logic [CW-1:0]            r_s1_addr;
    t_job_ctl                 r_s1_ctl;
    logic [LW-1:0]            s1_rd;
    cconv_pkg::t_pixel        above2;
    cconv_pkg::t_pixel        above1;

    // window and job
    cconv_pkg::t_pixel        r_window [3][3];
    t_job_ctl                 r_job_ctl;
    logic [3:0]               sel;
    logic                     lower_row;
    logic                     right_edge;
    logic [1:0]               top_row;
    logic [1:0]               mid_row;
    logic [1:0]               left_col;
    logic [1:0]               ctr_col;
    cconv_pkg::t_tap_item     n_p0_item;
    cconv_pkg::t_tap_item     r_p0_item;
    logic                     r_p0_valid;

    logic in_fire;
    logic s1_fire;
    logic job_issue;
    logic job_free;
    logic p0_ready;
    logic mac_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= cconv_pkg::WIDTH_RESET;
            r_cfg_height <= cconv_pkg::HEIGHT_RESET;
            r_kernel     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cconv_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg_data[cconv_pkg::WIDTH_REG_W-1:0];
                end
                cconv_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg_data[HW-1:0];
                end
                cconv_pkg::CFG_KERNEL_TOP: begin
                    r_kernel[0] <= i_cfg_data;
                end
                cconv_pkg::CFG_KERNEL_MIDDLE: begin
                    r_kernel[1] <= i_cfg_data;
                end
                cconv_pkg::CFG_KERNEL_BOTTOM: begin
                    r_kernel[2] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // clamp sizes and position
    always_comb begin
        w_ext = WW'(r_cfg_width);
        if (w_ext == '0) begin
            w_lim = WW'(1);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else begin
            w_lim = w_ext;
        end
        col_last = CW'(w_lim - WW'(1));

        if (r_cfg_height == '0) begin
            h_lim = HW'(1);
        end else if (r_cfg_height > cconv_pkg::HEIGHT_LIMIT) begin
            h_lim = cconv_pkg::HEIGHT_LIMIT;
        end else begin
            h_lim = r_cfg_height;
        end
        row_last = RW'(h_lim - HW'(1));

        cur_col  = (r_col >= col_last) ? col_last : r_col;
        cur_row  = (r_row >= row_last) ? row_last : r_row;
        last_col = (cur_col == col_last);
        last_row = (cur_row == row_last);

        n_s1_ctl.mask[0] = (cur_row != '0) && (cur_col != '0);
        n_s1_ctl.mask[1] = (cur_row != '0) && last_col;
        n_s1_ctl.mask[2] = last_row && (cur_col != '0);
        n_s1_ctl.mask[3] = last_row && last_col;
        n_s1_ctl.c_is0   = (cur_col == CW'(0));
        n_s1_ctl.c_is1   = (cur_col == CW'(1));
        n_s1_ctl.r_is0   = (cur_row == RW'(0));
        n_s1_ctl.r_is1   = (cur_row == RW'(1));
    end

    assign job_issue  = (r_job_ctl.mask != '0) && p0_ready;
    assign job_free   = (r_job_ctl.mask == '0) ||
                        (((r_job_ctl.mask & (r_job_ctl.mask - 4'd1)) == '0) && p0_ready);
    assign s1_fire    = r_s1_valid && job_free;
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : cur_row + RW'(1);
            end else begin
                r_col <= cur_col + CW'(1);
                r_row <= cur_row;
            end
        end
    end

    assign s1_rd  = r_s1_fwd ? r_fwd_data : r_rdata;
    assign above2 = s1_rd[LW-1:PXW];
    assign above1 = s1_rd[PXW-1:0];

    // line store: entry holds {two lines up, one line up}
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rdata <= r_line_mem[cur_col];
        end
        if (s1_fire) begin
            r_line_mem[r_s1_addr] <= {above1, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix   <= {i_blue, i_green, i_red};
            r_s1_addr  <= cur_col;
            r_s1_ctl   <= n_s1_ctl;
            r_s1_fwd   <= s1_fire && (r_s1_addr == cur_col);
            r_fwd_data <= {above1, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_window[i][j] <= '0;
                end
            end
        end else if (s1_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_window[i][0] <= r_window[i][1];
                r_window[i][1] <= r_window[i][2];
            end
            r_window[0][2] <= above2;
            r_window[1][2] <= above1;
            r_window[2][2] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_ctl <= '0;
        end else if (s1_fire) begin
            r_job_ctl <= r_s1_ctl;
        end else if (job_issue) begin
            r_job_ctl.mask <= r_job_ctl.mask & (r_job_ctl.mask - 4'd1);
        end
    end

    // tap selection for the lowest pending result of the job
    always_comb begin
        logic [1:0] rsel [3];
        logic [1:0] csel [3];
        sel        = r_job_ctl.mask & ~(r_job_ctl.mask - 4'd1);
        lower_row  = sel[2] || sel[3];
        right_edge = sel[1] || sel[3];
        top_row    = lower_row ? (r_job_ctl.r_is0 ? 2'd2 : 2'd1)
                               : (r_job_ctl.r_is1 ? 2'd1 : 2'd0);
        mid_row    = lower_row ? 2'd2 : 2'd1;
        left_col   = right_edge ? (r_job_ctl.c_is0 ? 2'd2 : 2'd1)
                                : (r_job_ctl.c_is1 ? 2'd1 : 2'd0);
        ctr_col    = right_edge ? 2'd2 : 2'd1;
        rsel[0] = top_row;
        rsel[1] = mid_row;
        rsel[2] = 2'd2;
        csel[0] = left_col;
        csel[1] = ctr_col;
        csel[2] = 2'd2;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                n_p0_item.taps[a*3+b] = r_window[rsel[a]][csel[b]];
            end
        end
        n_p0_item.frame_end = sel[3];
    end

    assign p0_ready = !r_p0_valid || !mac_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (p0_ready) begin
            r_p0_valid <= job_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_issue) begin
            r_p0_item <= n_p0_item;
        end
    end

    cconv_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_p0_valid),
        .i_item      (r_p0_item),
        .i_kernel    (r_kernel),
        .o_stall     (mac_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_sum   (o_red_sum),
        .o_green_sum (o_green_sum),
        .o_blue_sum  (o_blue_sum),
        .o_frame_end (o_frame_end)
    );

    // forwarding only happens when a line is one pixel wide
    a_fwd_width_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> (col_last == '0))
        else $error("line store forward with width above one");

    // a pixel waiting on a busy job keeps its slot
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("read stage lost its pixel");

    // last pixel of the frame wraps the position
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && last_row && last_col) |=> (r_row == '0 && r_col == '0))
        else $error("frame position did not wrap");

    // window only moves when the job is free
    a_window_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_job_ctl.mask != '0) && !s1_fire) |=> $stable(r_window[1][1]))
        else $error("window moved under a pending job");

endmodule

`default_nettype wire
